/* src/lru_block_buffer_cache_assert.svh */
// Assertion macros shared by the cache modules.
// Each macro takes a label, the clock, the active-low reset, a property or condition and a message.
`ifndef LRU_BLOCK_BUFFER_CACHE_ASSERT_SVH
`define LRU_BLOCK_BUFFER_CACHE_ASSERT_SVH
`ifndef SYNTHESIS
// Check that a property holds at every clock edge outside reset.
`define LBC_ASSERT(name_, clk_, rstn_, prop_, msg_) \
  name_: assert property (@(posedge clk_) disable iff (!rstn_) (prop_)) else $error(msg_);
// Check that a condition never holds at a clock edge outside reset.
`define LBC_ASSERT_NEVER(name_, clk_, rstn_, cond_, msg_) \
  name_: assert property (@(posedge clk_) disable iff (!rstn_) !(cond_)) else $error(msg_);
`else
`define LBC_ASSERT(name_, clk_, rstn_, prop_, msg_)
`define LBC_ASSERT_NEVER(name_, clk_, rstn_, cond_, msg_)
`endif
`endif

/* src/lbc_pkg.sv */
package lbc_pkg;

  // Request codes
  typedef enum logic [1:0] {
    OP_GET     = 2'd0,
    OP_RELEASE = 2'd1,
    OP_PIN     = 2'd2,
    OP_UNPIN   = 2'd3
  } op_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_NOBUF = 2'd1,
    ST_UNDER = 2'd2,
    ST_SAT   = 2'd3
  } status_e;

  // Request word
  typedef struct packed {
    op_e         op;
    logic [7:0]  device_number;
    logic [31:0] block_number;
    logic [4:0]  slot;
  } req_t;

  // Result word
  typedef struct packed {
    logic [4:0] slot_out;
    logic       hit;
    logic       fetch_needed;
    status_e    status;
  } rsp_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;
    logic lookup;
    logic commit;
  } ctrl_cmd_t;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_LOOKUP = 3'b010,
    S_COMMIT = 3'b100
  } state_e;

endpackage

/* src/lbc_ctrl.sv */
`include "lru_block_buffer_cache_assert.svh"

module lbc_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output lbc_pkg::ctrl_cmd_t    cmd_o
);

  lbc_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;
  logic            commit_go;

  // Commit only when the output register is free or being emptied
  assign commit_go  = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == lbc_pkg::S_IDLE) ||
                      ((state_q == lbc_pkg::S_COMMIT) && commit_go);

  // Sequence lookup and commit, issue datapath commands
  always_comb begin
    state_d        = state_q;
    out_valid_d    = out_valid_q && !out_ready_i;
    cmd_o          = '0;
    cmd_o.capture  = in_valid_i && in_ready_o;
    unique case (state_q)
      lbc_pkg::S_IDLE: begin
        if (in_valid_i) begin
          state_d = lbc_pkg::S_LOOKUP;
        end
      end
      lbc_pkg::S_LOOKUP: begin
        cmd_o.lookup = 1'b1;
        state_d      = lbc_pkg::S_COMMIT;
      end
      lbc_pkg::S_COMMIT: begin
        if (commit_go) begin
          cmd_o.commit = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = in_valid_i ? lbc_pkg::S_LOOKUP : lbc_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = lbc_pkg::S_IDLE;
      end
    endcase
  end

  // Hold state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lbc_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `LBC_ASSERT(a_accept_to_lookup, clk_i, rst_ni, in_valid_i && in_ready_o |=> state_q == lbc_pkg::S_LOOKUP, "accepted word did not enter lookup")
  `LBC_ASSERT(a_lookup_to_commit, clk_i, rst_ni, state_q == lbc_pkg::S_LOOKUP |=> state_q == lbc_pkg::S_COMMIT, "lookup not followed by commit")
  `LBC_ASSERT(a_valid_from_commit, clk_i, rst_ni, $rose(out_valid_q) |-> $past(cmd_o.commit), "result valid without a commit")

endmodule

/* src/lbc_datapath.sv */
`include "lru_block_buffer_cache_assert.svh"

module lbc_datapath #(
  parameter int unsigned SLOTS    = 32,
  parameter int unsigned MAX_REFS = 127
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lbc_pkg::ctrl_cmd_t cmd_i,
  input  lbc_pkg::req_t      req_i,
  output lbc_pkg::rsp_t      rsp_o
);

  localparam int unsigned IW = $clog2(SLOTS);
  localparam int unsigned CW = $clog2(MAX_REFS + 1);
  localparam logic [CW-1:0] CntMax  = CW'(MAX_REFS);
  localparam logic [IW-1:0] RankTop = IW'(SLOTS - 1);

  // Slot state: tags, contents valid, reference counts, recency rank
  logic [7:0]       tag_dev_q [SLOTS];
  logic [31:0]      tag_blk_q [SLOTS];
  logic [CW-1:0]    cnt_q     [SLOTS];
  logic [IW-1:0]    rank_q    [SLOTS];
  logic [SLOTS-1:0] valid_q;

  lbc_pkg::req_t    req_q;
  lbc_pkg::rsp_t    rsp_q, rsp_d;
  logic [SLOTS-1:0] hit_pos_q, hit_pos_d, free_pos_q, free_pos_d;

  logic             hit_any, free_any, is_get, slot_ok;
  logic [SLOTS-1:0] hit_rev, hit_rev_low, hit_top, free_low, pos_sel, sel;
  logic [IW-1:0]    win_idx, sel_rank;
  logic             sel_zero, sel_one, sel_max, sel_valid;
  logic             do_inc, do_dec, do_load, do_valid, do_move;

  // Latch the accepted request word
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q <= req_i;
    end
  end

  // Map tag matches and free slots onto recency positions
  always_comb begin
    hit_pos_d  = '0;
    free_pos_d = '0;
    for (int s = 0; s < SLOTS; s++) begin
      if (tag_dev_q[s] == req_q.device_number && tag_blk_q[s] == req_q.block_number) begin
        hit_pos_d[rank_q[s]] = 1'b1;
      end
      if (cnt_q[s] == '0) begin
        free_pos_d[rank_q[s]] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.lookup) begin
      hit_pos_q  <= hit_pos_d;
      free_pos_q <= free_pos_d;
    end
  end

  // Pick most recent hit and least recent free slot
  assign hit_any     = |hit_pos_q;
  assign free_any    = |free_pos_q;
  assign hit_rev_low = hit_rev & (~hit_rev + SLOTS'(1));
  assign free_low    = free_pos_q & (~free_pos_q + SLOTS'(1));

  always_comb begin
    for (int p = 0; p < SLOTS; p++) begin
      hit_rev[p]           = hit_pos_q[SLOTS-1-p];
      hit_top[SLOTS-1-p]   = hit_rev_low[p];
    end
  end

  assign is_get  = (req_q.op == lbc_pkg::OP_GET);
  assign slot_ok = (32'(req_q.slot) < SLOTS);
  assign pos_sel = hit_any ? hit_top : free_low;

  // Select the target slot and gather its attributes
  always_comb begin
    sel       = '0;
    win_idx   = '0;
    sel_rank  = '0;
    sel_zero  = 1'b0;
    sel_one   = 1'b0;
    sel_max   = 1'b0;
    sel_valid = 1'b0;
    for (int s = 0; s < SLOTS; s++) begin
      if (is_get) begin
        sel[s] = pos_sel[rank_q[s]];
      end else begin
        sel[s] = slot_ok && (32'(req_q.slot) == 32'(s));
      end
      if (sel[s]) begin
        win_idx   = win_idx | IW'(s);
        sel_rank  = sel_rank | rank_q[s];
        sel_zero  = sel_zero | (cnt_q[s] == '0);
        sel_one   = sel_one | (cnt_q[s] == CW'(1));
        sel_max   = sel_max | (cnt_q[s] >= CntMax);
        sel_valid = sel_valid | valid_q[s];
      end
    end
  end

  // Decide the result and the state updates
  always_comb begin
    rsp_d              = '0;
    rsp_d.slot_out     = req_q.slot;
    rsp_d.status       = lbc_pkg::ST_OK;
    do_inc             = 1'b0;
    do_dec             = 1'b0;
    do_load            = 1'b0;
    do_valid           = 1'b0;
    do_move            = 1'b0;
    unique case (req_q.op)
      lbc_pkg::OP_GET: begin
        priority if (hit_any) begin
          rsp_d.slot_out = 5'(win_idx);
          rsp_d.hit      = 1'b1;
          if (sel_max) begin
            rsp_d.status = lbc_pkg::ST_SAT;
          end else begin
            do_inc             = 1'b1;
            do_valid           = 1'b1;
            rsp_d.fetch_needed = !sel_valid;
          end
        end else if (free_any) begin
          rsp_d.slot_out     = 5'(win_idx);
          rsp_d.fetch_needed = 1'b1;
          do_load            = 1'b1;
          do_valid           = 1'b1;
        end else begin
          rsp_d.slot_out = '0;
          rsp_d.status   = lbc_pkg::ST_NOBUF;
        end
      end
      lbc_pkg::OP_PIN: begin
        priority if (!slot_ok) begin
          rsp_d.status = lbc_pkg::ST_NOBUF;
        end else if (sel_max) begin
          rsp_d.status = lbc_pkg::ST_SAT;
        end else begin
          do_inc = 1'b1;
        end
      end
      lbc_pkg::OP_RELEASE, lbc_pkg::OP_UNPIN: begin
        priority if (!slot_ok) begin
          rsp_d.status = lbc_pkg::ST_NOBUF;
        end else if (sel_zero) begin
          rsp_d.status = lbc_pkg::ST_UNDER;
        end else begin
          do_dec  = 1'b1;
          do_move = (req_q.op == lbc_pkg::OP_RELEASE) && sel_one;
        end
      end
      default: begin
        rsp_d.status = lbc_pkg::ST_OK;
      end
    endcase
  end

  // Update slot state on commit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      for (int s = 0; s < SLOTS; s++) begin
        tag_dev_q[s] <= '0;
        tag_blk_q[s] <= '0;
        cnt_q[s]     <= '0;
        rank_q[s]    <= IW'(s);
      end
    end else if (cmd_i.commit) begin
      for (int s = 0; s < SLOTS; s++) begin
        if (sel[s]) begin
          if (do_inc) begin
            cnt_q[s] <= cnt_q[s] + CW'(1);
          end
          if (do_dec) begin
            cnt_q[s] <= cnt_q[s] - CW'(1);
          end
          if (do_load) begin
            cnt_q[s]     <= CW'(1);
            tag_dev_q[s] <= req_q.device_number;
            tag_blk_q[s] <= req_q.block_number;
          end
          if (do_valid) begin
            valid_q[s] <= 1'b1;
          end
        end
        // When a release drops a slot's count to zero, move it to most recent, close the gap behind it
        if (do_move) begin
          if (sel[s]) begin
            rank_q[s] <= RankTop;
          end else if (rank_q[s] > sel_rank) begin
            rank_q[s] <= rank_q[s] - IW'(1);
          end
        end
      end
    end
  end

  // Hold the result word until taken
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_o = rsp_q;

  `LBC_ASSERT_NEVER(a_sel_onehot, clk_i, rst_ni, cmd_i.commit && !$onehot0(sel), "more than one slot selected")
  `LBC_ASSERT_NEVER(a_pick_onehot, clk_i, rst_ni, cmd_i.commit && is_get && !$onehot0(pos_sel), "recency pick not one-hot")
  `LBC_ASSERT(a_move_ok, clk_i, rst_ni, cmd_i.commit && do_move |=> rsp_q.status == lbc_pkg::ST_OK, "slot moved on a failed release")

endmodule

/* src/lru_block_buffer_cache.sv */
// Channel | Handshake             | Word
// --------+-----------------------+--------------------------------------------
// in      | in_valid_i/in_ready_o | in_req_i: op, device, block, slot
// out     | out_valid_o/out_ready_i | out_rsp_o: slot_out, hit, fetch, status
//
// Each word passes a lookup step, which maps tag matches and free slots onto
// recency positions, and a commit step, which picks the slot and updates its state.
// The next word is taken in the commit cycle; the result sits in an output register.
// Reset clears tags, counts and valid bits at once; no clearing pass is needed.
// Commit stalls while the output register holds a result not yet taken.
module lru_block_buffer_cache #(
  parameter int unsigned SLOTS    = 32,
  parameter int unsigned MAX_REFS = 127
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  lbc_pkg::req_t in_req_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output lbc_pkg::rsp_t out_rsp_o
);

  lbc_pkg::ctrl_cmd_t cmd;

  // Sequence each word through lookup and commit
  lbc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  // Hold slot state and compute results
  lbc_datapath #(
    .SLOTS    (SLOTS),
    .MAX_REFS (MAX_REFS)
  ) u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .req_i  (in_req_i),
    .rsp_o  (out_rsp_o)
  );

endmodule
